>>> rtl/slt_pkg.sv
// Shared types, constants and helpers for the script label table.
`default_nettype none

package slt_pkg;

    // Table geometry
    localparam int MAX_LABELS    = 32;
    localparam int NAME_BYTES    = 31;
    localparam int PROGRAM_BYTES = 65536;
    localparam int PREFIX_LEN    = 6;
    localparam int LOOK_LEN_MAX  = 63;

    // Derived widths
    localparam int IDX_W   = $clog2(MAX_LABELS);
    localparam int TOTAL_W = $clog2(MAX_LABELS + 1);
    localparam int NAME_AW = $clog2(NAME_BYTES);
    localparam int LEN_W   = $clog2(NAME_BYTES + 1);
    localparam int POS_W   = 17;
    localparam int LOOK_W  = 6;
    localparam int PFX_W   = 3;

    // Character codes
    localparam logic [7:0] CHAR_NL  = 8'h0A;
    localparam logic [7:0] CHAR_NUL = 8'h00;

    // Item command codes
    localparam logic CMD_SCAN   = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // Result kind codes
    localparam logic KIND_SCAN   = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    // Input item
    typedef struct packed {
        logic       command;
        logic [7:0] char_in;
        logic       last;
    } slt_req_t;

    // Result item
    typedef struct packed {
        logic               kind;
        logic               found;
        logic [POS_W-1:0]   position;
        logic [TOTAL_W-1:0] label_total_out;
    } slt_rsp_t;

    // Line scanner modes
    typedef enum logic [1:0] {
        MODE_PREFIX,
        MODE_CAPTURE,
        MODE_FROZEN,
        MODE_SKIP
    } line_mode_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_ANSWER
    } ctrl_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic scan_step;
        logic char_take;
        logic match_step;
        logic answer_load;
    } slt_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic char_last;
        logic rsp_busy;
    } slt_stat_t;

    // Byte of the label prefix at a given offset
    function automatic logic [7:0] prefix_char(input logic [PFX_W-1:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0:    ch = 8'h6C;
            3'd1:    ch = 8'h61;
            3'd2:    ch = 8'h62;
            3'd3:    ch = 8'h65;
            3'd4:    ch = 8'h6C;
            3'd5:    ch = 8'h20;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

>>> rtl/slt_ram.sv
// Generic single-port-write RAM with registered read.
`default_nettype none

module slt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 31
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output      logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

>>> rtl/slt_ctrl.sv
// Controller state machine: sequences scan bytes and lookup characters.
`default_nettype none

module slt_ctrl
    import slt_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    input  wire logic      req_command,
    input  wire logic      req_last,
    output      logic      req_stall,
    input  wire slt_stat_t stat,
    output      slt_cmd_t  cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        take;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = 1'b1;
        take       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                // hold a final item while the result register is occupied
                req_stall = stat.rsp_busy && req_last;
                take      = req_valid && !req_stall;
                if (take && req_command == CMD_SCAN)
                begin
                    cmd.scan_step = 1'b1;
                end
                else if (take)
                begin
                    cmd.char_take = 1'b1;
                    state_next    = ST_MATCH;
                end
            end
            ST_MATCH:
            begin
                cmd.match_step = 1'b1;
                state_next     = stat.char_last ? ST_ANSWER : ST_IDLE;
            end
            ST_ANSWER:
            begin
                cmd.answer_load = 1'b1;
                state_next      = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/slt_datapath.sv
// Datapath: line scanner, label table, parallel lookup and result register.
`default_nettype none

module slt_datapath
    import slt_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire slt_req_t  req,
    input  wire slt_cmd_t  cmd,
    output      slt_stat_t stat,
    output      logic      rsp_valid,
    input  wire logic      rsp_stall,
    output      slt_rsp_t  rsp
);

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = TOTAL_W'(MAX_LABELS);
    localparam logic [POS_W-1:0]   POS_MAX   = POS_W'(PROGRAM_BYTES);
    localparam logic [LEN_W-1:0]   NAME_MAX  = LEN_W'(NAME_BYTES);
    localparam logic [LOOK_W-1:0]  LOOK_MAX  = LOOK_W'(LOOK_LEN_MAX);
    localparam logic [PFX_W-1:0]   PFX_FULL  = PFX_W'(PREFIX_LEN);

    // Scan state
    logic [TOTAL_W-1:0] label_total_reg;
    logic [POS_W-1:0]   byte_pos_reg;
    line_mode_t         mode_reg;
    logic [PFX_W-1:0]   prefix_reg;
    logic [LEN_W-1:0]   cap_len_reg;
    logic               scan_open_reg;

    // Lookup state
    logic [MAX_LABELS-1:0] cand_reg;
    logic [LOOK_W-1:0]     look_len_reg;
    logic                  look_end_reg;
    logic [7:0]            char_reg;
    logic                  last_reg;

    // Label table
    logic [LEN_W-1:0] name_len_reg [MAX_LABELS];
    logic [POS_W-1:0] label_pos_reg [MAX_LABELS];
    logic [7:0]       name_rd [MAX_LABELS];

    // Result register
    slt_rsp_t rsp_reg;
    logic     rsp_valid_reg;

    // Scan step signals
    logic [TOTAL_W-1:0] eff_total;
    logic [POS_W-1:0]   eff_pos;
    line_mode_t         eff_mode;
    logic [PFX_W-1:0]   eff_prefix;
    logic [LEN_W-1:0]   eff_cap;
    logic               is_nl;
    logic [POS_W-1:0]   pos_inc;
    line_mode_t         mode_s;
    logic [PFX_W-1:0]   prefix_s;
    logic [LEN_W-1:0]   cap_s;
    logic               line_clear;
    logic               rec;
    logic               rec_store;
    logic [POS_W-1:0]   rec_pos;
    logic               name_wr;
    logic [TOTAL_W-1:0] total_next;
    logic [POS_W-1:0]   pos_next;
    line_mode_t         mode_next;
    logic [PFX_W-1:0]   prefix_next;
    logic [LEN_W-1:0]   cap_next;

    // Lookup signals
    logic [NAME_AW-1:0]    rd_addr;
    logic [MAX_LABELS-1:0] keep_vec;
    logic [MAX_LABELS-1:0] hit_vec;
    logic [IDX_W-1:0]      hit_idx;
    logic                  hit_any;

    // Scan one program byte
    always_comb
    begin
        eff_total  = scan_open_reg ? label_total_reg : '0;
        eff_pos    = scan_open_reg ? byte_pos_reg : '0;
        eff_mode   = scan_open_reg ? mode_reg : MODE_PREFIX;
        eff_prefix = scan_open_reg ? prefix_reg : '0;
        eff_cap    = scan_open_reg ? cap_len_reg : '0;
        is_nl      = (req.char_in == CHAR_NL);
        pos_inc    = (eff_pos < POS_MAX) ? eff_pos + 1'b1 : eff_pos;
        mode_s     = eff_mode;
        prefix_s   = eff_prefix;
        cap_s      = eff_cap;
        line_clear = 1'b0;
        rec        = 1'b0;
        rec_pos    = eff_pos;
        name_wr    = 1'b0;
        if (is_nl)
        begin
            line_clear = 1'b1;
            rec        = (eff_mode == MODE_CAPTURE) || (eff_mode == MODE_FROZEN);
        end
        else
        begin
            unique case (eff_mode)
                MODE_PREFIX:
                begin
                    if (eff_prefix < PFX_FULL && req.char_in == prefix_char(eff_prefix))
                    begin
                        prefix_s = eff_prefix + 1'b1;
                        if (prefix_s == PFX_FULL)
                        begin
                            mode_s = MODE_CAPTURE;
                            cap_s  = '0;
                        end
                    end
                    else
                    begin
                        mode_s = MODE_SKIP;
                    end
                end
                MODE_CAPTURE:
                begin
                    if (req.char_in == CHAR_NUL)
                    begin
                        mode_s = MODE_FROZEN;
                    end
                    else if (eff_cap < NAME_MAX)
                    begin
                        name_wr = (eff_total < TOTAL_MAX);
                        cap_s   = eff_cap + 1'b1;
                        if (cap_s >= NAME_MAX)
                        begin
                            mode_s = MODE_FROZEN;
                        end
                    end
                end
                MODE_FROZEN, MODE_SKIP:
                begin
                    mode_s = eff_mode;
                end
            endcase
        end
        // close a label cut short by the end of the program
        if (req.last && !is_nl && (mode_s == MODE_CAPTURE || mode_s == MODE_FROZEN))
        begin
            rec     = 1'b1;
            rec_pos = pos_inc;
        end
        rec_store  = rec && (eff_total < TOTAL_MAX);
        total_next = eff_total + TOTAL_W'(rec_store);
        if (line_clear || req.last)
        begin
            mode_next   = MODE_PREFIX;
            prefix_next = '0;
            cap_next    = '0;
        end
        else
        begin
            mode_next   = mode_s;
            prefix_next = prefix_s;
            cap_next    = cap_s;
        end
        pos_next = req.last ? '0 : pos_inc;
    end

    // Scan state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            label_total_reg <= '0;
            byte_pos_reg    <= '0;
            mode_reg        <= MODE_PREFIX;
            prefix_reg      <= '0;
            cap_len_reg     <= '0;
            scan_open_reg   <= 1'b0;
        end
        else if (cmd.scan_step)
        begin
            label_total_reg <= total_next;
            byte_pos_reg    <= pos_next;
            mode_reg        <= mode_next;
            prefix_reg      <= prefix_next;
            cap_len_reg     <= cap_next;
            scan_open_reg   <= !req.last;
        end
    end

    // Record label length and position
    always_ff @(posedge clk)
    begin
        if (cmd.scan_step && rec_store)
        begin
            name_len_reg[eff_total[IDX_W-1:0]]  <= cap_s;
            label_pos_reg[eff_total[IDX_W-1:0]] <= rec_pos;
        end
    end

    // Name banks: one per label, all read at the current lookup column
    assign rd_addr = (look_len_reg < LOOK_W'(NAME_BYTES)) ? look_len_reg[NAME_AW-1:0] : '0;

    for (genvar g = 0; g < MAX_LABELS; g++)
    begin : g_bank
        slt_ram #(
            .WIDTH(8),
            .DEPTH(NAME_BYTES)
        ) u_name_ram (
            .clk    (clk),
            .wr_en  (cmd.scan_step && name_wr && eff_total[IDX_W-1:0] == IDX_W'(g)),
            .wr_addr(eff_cap[NAME_AW-1:0]),
            .wr_data(req.char_in),
            .rd_addr(rd_addr),
            .rd_data(name_rd[g])
        );
    end

    // Compare the held character against every label
    always_comb
    begin
        for (int i = 0; i < MAX_LABELS; i++)
        begin
            keep_vec[i] = (TOTAL_W'(i) < label_total_reg)
                       && (look_len_reg < LOOK_W'(name_len_reg[i]))
                       && (look_len_reg < LOOK_W'(NAME_BYTES))
                       && (name_rd[i] == char_reg);
        end
    end

    // Pick the first label that survived with the same length
    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < MAX_LABELS; i++)
        begin
            hit_vec[i] = cand_reg[i] && (TOTAL_W'(i) < label_total_reg)
                      && (LOOK_W'(name_len_reg[i]) == look_len_reg);
        end
        for (int i = MAX_LABELS - 1; i >= 0; i--)
        begin
            if (hit_vec[i])
            begin
                hit_idx = IDX_W'(i);
            end
        end
        hit_any = |hit_vec;
    end

    // Lookup state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_reg     <= '1;
            look_len_reg <= '0;
            look_end_reg <= 1'b0;
        end
        else if (cmd.answer_load)
        begin
            cand_reg     <= '1;
            look_len_reg <= '0;
            look_end_reg <= 1'b0;
        end
        else if (cmd.match_step && !look_end_reg)
        begin
            if (char_reg == CHAR_NUL)
            begin
                look_end_reg <= 1'b1;
            end
            else
            begin
                cand_reg <= cand_reg & keep_vec;
                if (look_len_reg < LOOK_MAX)
                begin
                    look_len_reg <= look_len_reg + 1'b1;
                end
            end
        end
    end

    // Hold the lookup character
    always_ff @(posedge clk)
    begin
        if (cmd.char_take)
        begin
            char_reg <= req.char_in;
            last_reg <= req.last;
        end
    end

    // Result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if ((cmd.scan_step && req.last) || cmd.answer_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (cmd.scan_step && req.last)
        begin
            rsp_reg.kind            <= KIND_SCAN;
            rsp_reg.found           <= 1'b0;
            rsp_reg.position        <= '0;
            rsp_reg.label_total_out <= total_next;
        end
        else if (cmd.answer_load)
        begin
            rsp_reg.kind            <= KIND_LOOKUP;
            rsp_reg.found           <= hit_any;
            rsp_reg.position        <= hit_any ? label_pos_reg[hit_idx] : '0;
            rsp_reg.label_total_out <= label_total_reg;
        end
    end

    assign rsp_valid      = rsp_valid_reg;
    assign rsp            = rsp_reg;
    assign stat.char_last = last_reg;
    assign stat.rsp_busy  = rsp_valid_reg;

endmodule

`default_nettype wire

>>> rtl/script_label_table_core.sv
// Top level of the script label table: controller plus datapath.
//
//  Channel | Valid     | Stall     | Payload
//  --------+-----------+-----------+----------------------------------------
//  request | req_valid | req_stall | req: command, char_in, last
//  result  | rsp_valid | rsp_stall | rsp: kind, found, position, label_total_out
//
// A program byte updates the name banks and the line scanner as it is taken.
// A lookup character is taken while the name banks are read, then compared against all
// labels in parallel; after the final one, the first matching label is picked.
// Reset clears the scanner, the lookup state and the result valid flag; the label
// table is written by scanning only. A final item is held off while a result waits.
`default_nettype none

module script_label_table_core
    import slt_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output      logic     req_stall,
    input  wire slt_req_t req,
    output      logic     rsp_valid,
    input  wire logic     rsp_stall,
    output      slt_rsp_t rsp
);

    slt_cmd_t  cmd;
    slt_stat_t stat;

    slt_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_command(req.command),
        .req_last   (req.last),
        .req_stall  (req_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    slt_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .cmd      (cmd),
        .stat     (stat),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp)
    );

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the script label table: label scan, lookup and result checks.
`default_nettype none

module tb_top
    import slt_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [47:0] LABEL_WORD = "label ";
    localparam int          LOOK_SAT   = 63;
    localparam int          POOL_SIZE  = 64;
    localparam int          POOL_BYTES = 40;
    localparam int          HOLD_CYCLES = 300;

    // Shadow of the label table; predicts scan reports and lookup answers
    class label_table_board;
        logic [7:0]   name_bank [MAX_LABELS][NAME_BYTES];
        int unsigned  name_len [MAX_LABELS];
        int unsigned  pos_tab [MAX_LABELS];
        int unsigned  total;
        int unsigned  byte_pos;
        int unsigned  prefix_cnt;
        int unsigned  cap_len;
        int unsigned  look_len;
        line_mode_t   mode;
        bit           scan_open;
        bit           look_ended;
        logic [MAX_LABELS-1:0] candidates;
        slt_rsp_t     pending [$];
        int           errors;
        int           checked;
        int           items_noted;
        int           scan_reports;
        int           lookup_answers;
        int           lookup_found;

        function new();
            foreach (name_bank[i, j]) name_bank[i][j] = 8'h00;
            foreach (name_len[i]) name_len[i] = 0;
            foreach (pos_tab[i]) pos_tab[i] = 0;
            total = 0;
            byte_pos = 0;
            scan_open = 0;
            errors = 0;
            checked = 0;
            items_noted = 0;
            scan_reports = 0;
            lookup_answers = 0;
            lookup_found = 0;
            clear_line();
            clear_lookup();
        endfunction

        function void clear_line();
            mode = MODE_PREFIX;
            prefix_cnt = 0;
            cap_len = 0;
        endfunction

        function void clear_lookup();
            candidates = '1;
            look_len = 0;
            look_ended = 0;
        endfunction

        function void record_label(int unsigned at);
            if (total < MAX_LABELS) begin
                name_len[total] = cap_len;
                pos_tab[total] = at;
                total++;
            end
        endfunction

        // Advance the shadow state by one accepted item; queue its result if any
        function void note_item(slt_req_t it);
            slt_rsp_t    res;
            int unsigned here;
            logic [7:0]  c;
            bit          keep;
            bit          hit;
            res = '0;
            c = it.char_in;
            hit = 0;
            items_noted++;
            if (it.command == CMD_SCAN) begin
                // First byte of a program empties the table
                if (!scan_open) begin
                    total = 0;
                    byte_pos = 0;
                    clear_line();
                    scan_open = 1;
                end
                here = byte_pos;
                if (byte_pos < PROGRAM_BYTES)
                    byte_pos++;
                case (mode)
                    MODE_PREFIX:
                        if (c == CHAR_NL)
                            clear_line();
                        else if (prefix_cnt < PREFIX_LEN &&
                                 c == LABEL_WORD[47 - 8 * prefix_cnt -: 8]) begin
                            prefix_cnt++;
                            if (prefix_cnt == PREFIX_LEN) begin
                                mode = MODE_CAPTURE;
                                cap_len = 0;
                            end
                        end
                        else
                            mode = MODE_SKIP;
                    MODE_CAPTURE, MODE_FROZEN:
                        if (c == CHAR_NL) begin
                            record_label(here);
                            clear_line();
                        end
                        else if (mode == MODE_CAPTURE) begin
                            if (c == CHAR_NUL)
                                mode = MODE_FROZEN;
                            else if (cap_len < NAME_BYTES) begin
                                if (total < MAX_LABELS)
                                    name_bank[total][cap_len] = c;
                                cap_len++;
                                if (cap_len >= NAME_BYTES)
                                    mode = MODE_FROZEN;
                            end
                        end
                    default:
                        if (c == CHAR_NL)
                            clear_line();
                endcase
                if (it.last) begin
                    // Program ended inside a label line: close it at the program length
                    if (c != CHAR_NL && (mode == MODE_CAPTURE || mode == MODE_FROZEN))
                        record_label(byte_pos);
                    clear_line();
                    byte_pos = 0;
                    scan_open = 0;
                    res.kind = KIND_SCAN;
                    res.label_total_out = TOTAL_W'(total);
                    pending.push_back(res);
                    scan_reports++;
                end
            end
            else begin
                // Narrow the candidate set by one name character
                if (!look_ended) begin
                    if (c == CHAR_NUL)
                        look_ended = 1;
                    else begin
                        for (int i = 0; i < MAX_LABELS; i++) begin
                            keep = 0;
                            if (i < total && look_len < name_len[i] && look_len < NAME_BYTES)
                                keep = (name_bank[i][look_len] == c);
                            if (!keep)
                                candidates[i] = 1'b0;
                        end
                        if (look_len < LOOK_SAT)
                            look_len++;
                    end
                end
                if (it.last) begin
                    res.kind = KIND_LOOKUP;
                    for (int i = 0; i < MAX_LABELS; i++) begin
                        if (!hit && i < total && candidates[i] && name_len[i] == look_len) begin
                            hit = 1;
                            res.position = POS_W'(pos_tab[i]);
                        end
                    end
                    res.found = hit;
                    res.label_total_out = TOTAL_W'(total);
                    pending.push_back(res);
                    lookup_answers++;
                    if (hit)
                        lookup_found++;
                    clear_lookup();
                end
            end
        endfunction

        // Compare one accepted result with the oldest expectation
        function void check_result(slt_rsp_t got);
            slt_rsp_t want;
            if (pending.size() == 0) begin
                $display("%0t: result with nothing expected: kind=%0d found=%0d pos=%0d total=%0d",
                         $time, got.kind, got.found, got.position, got.label_total_out);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.kind !== want.kind) begin
                $display("%0t: kind mismatch: expected %0d, actual %0d",
                         $time, want.kind, got.kind);
                errors++;
            end
            if (got.found !== want.found) begin
                $display("%0t: found mismatch: expected %0d, actual %0d",
                         $time, want.found, got.found);
                errors++;
            end
            if (got.position !== want.position) begin
                $display("%0t: position mismatch: expected %0d, actual %0d",
                         $time, want.position, got.position);
                errors++;
            end
            if (got.label_total_out !== want.label_total_out) begin
                $display("%0t: label_total_out mismatch: expected %0d, actual %0d",
                         $time, want.label_total_out, got.label_total_out);
                errors++;
            end
        endfunction
    endclass

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_stall;
    slt_req_t req = '0;
    logic     rsp_valid;
    logic     rsp_stall = 1'b0;
    slt_rsp_t rsp;

    label_table_board board;

    // Stimulus controls: written by the main sequence only
    bit  idle_on = 1'b0;
    int  stall_mode = 0;
    bit  hold_request = 1'b0;

    // Receiver state: written by the receiver process only
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    int  pat_cnt = 0;

    int  burst_left = 0;

    logic [7:0] prog_q [$];
    logic [7:0] look_q [$];
    logic [7:0] name_pool [POOL_SIZE][POOL_BYTES];
    int         name_pool_len [POOL_SIZE];
    int         pool_count = 0;
    int         pool_wr = 0;

    script_label_table_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // Hard stop well beyond the slowest correct run
    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Receiver: drive stall on its own pattern, with one long hold-off on request
    initial begin
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                rsp_stall <= 1'b1;
                hold_left--;
            end
            else if (hold_request && !hold_done) begin
                hold_left = HOLD_CYCLES - 1;
                hold_done = 1'b1;
                rsp_stall <= 1'b1;
            end
            else begin
                pat_cnt++;
                case (stall_mode)
                    0:       rsp_stall <= 1'b0;
                    1:       rsp_stall <= ($urandom_range(0, 3) == 0);
                    2:       rsp_stall <= ((pat_cnt % 7) >= 4);
                    default: rsp_stall <= ($urandom_range(0, 1) == 1);
                endcase
            end
        end
    end

    // Result monitor
    initial begin
        forever begin
            @(posedge clk);
            if (rst_n && rsp_valid === 1'b1 && rsp_stall === 1'b0)
                board.check_result(rsp);
        end
    end

    function automatic slt_req_t make_item(logic cmd, logic [7:0] ch, logic fin);
        slt_req_t it;
        it.command = cmd;
        it.char_in = ch;
        it.last = fin;
        return it;
    endfunction

    // Offer one item, idling between bursts, and hold it until accepted
    task automatic push_item(input slt_req_t it);
        int gap;
        if (burst_left == 0) begin
            gap = idle_on ? $urandom_range(0, 6) : 0;
            repeat (gap) begin
                @(negedge clk);
                req_valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge clk);
        req_valid <= 1'b1;
        req <= it;
        do @(posedge clk); while (req_stall !== 1'b0);
        board.note_item(it);
    endtask

    task automatic send_stream(input logic cmd);
        int n;
        n = (cmd == CMD_SCAN) ? prog_q.size() : look_q.size();
        for (int k = 0; k < n; k++)
            push_item(make_item(cmd, (cmd == CMD_SCAN) ? prog_q[k] : look_q[k], k == n - 1));
    endtask

    // Interleave the pending program and lookup name, keeping each in order
    task automatic send_mixed();
        int i;
        int j;
        bit take_prog;
        i = 0;
        j = 0;
        while (i < prog_q.size() || j < look_q.size()) begin
            if (i >= prog_q.size())
                take_prog = 0;
            else if (j >= look_q.size())
                take_prog = 1;
            else
                take_prog = ($urandom_range(0, 2) != 0);
            if (take_prog) begin
                push_item(make_item(CMD_SCAN, prog_q[i], i == prog_q.size() - 1));
                i++;
            end
            else begin
                push_item(make_item(CMD_LOOKUP, look_q[j], j == look_q.size() - 1));
                j++;
            end
        end
    endtask

    function automatic void add_text(string s);
        for (int k = 0; k < s.len(); k++)
            prog_q.push_back(s[k]);
    endfunction

    task automatic lookup_text(string s);
        look_q.delete();
        for (int k = 0; k < s.len(); k++)
            look_q.push_back(s[k]);
        if (look_q.size() == 0)
            look_q.push_back(CHAR_NUL);
        send_stream(CMD_LOOKUP);
    endtask

    task automatic lookup_long(int n);
        look_q.delete();
        for (int k = 0; k < n; k++)
            look_q.push_back(8'h6B + k % 3);
        send_stream(CMD_LOOKUP);
    endtask

    // Mostly a small alphabet so names collide and share prefixes
    function automatic logic [7:0] name_char();
        int         r;
        logic [7:0] b;
        r = $urandom_range(0, 99);
        if (r < 85)
            return 8'h61 + $urandom_range(0, 3);
        if (r < 97) begin
            b = $urandom_range(1, 255);
            if (b == CHAR_NL)
                b = 8'hFE;
            return b;
        end
        return CHAR_NUL;
    endfunction

    function automatic int pick_name_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 0;
        if (r < 75)
            return $urandom_range(1, 6);
        if (r < 92)
            return $urandom_range(7, 31);
        return $urandom_range(32, POOL_BYTES);
    endfunction

    // Append a label line and remember its name for later lookups
    function automatic void add_label_line(int n, bit with_nl);
        logic [7:0] c;
        add_text("label ");
        for (int k = 0; k < n; k++) begin
            c = name_char();
            prog_q.push_back(c);
            name_pool[pool_wr][k] = c;
        end
        name_pool_len[pool_wr] = n;
        pool_wr = (pool_wr + 1) % POOL_SIZE;
        if (pool_count < POOL_SIZE)
            pool_count++;
        if (with_nl)
            prog_q.push_back(CHAR_NL);
    endfunction

    // Append a line that breaks off the prefix, or an empty line
    function automatic void add_junk_line();
        int         k;
        logic [7:0] b;
        k = $urandom_range(0, 5);
        for (int p = 0; p < k; p++)
            prog_q.push_back(LABEL_WORD[47 - 8 * p -: 8]);
        if ($urandom_range(0, 3) != 0) begin
            do b = $urandom_range(0, 255);
            while (b == LABEL_WORD[47 - 8 * k -: 8] || b == CHAR_NL);
            prog_q.push_back(b);
            repeat ($urandom_range(0, 8)) begin
                b = $urandom_range(0, 255);
                prog_q.push_back(b == CHAR_NL ? 8'h0B : b);
            end
        end
        prog_q.push_back(CHAR_NL);
    endfunction

    function automatic void gen_program();
        int lines;
        int r;
        prog_q.delete();
        if ($urandom_range(0, 11) == 0) begin
            // Overfill the table with short names
            repeat ($urandom_range(33, 38)) add_label_line($urandom_range(1, 2), 1);
        end
        else begin
            lines = $urandom_range(0, 8);
            repeat (lines) begin
                if ($urandom_range(0, 9) < 7)
                    add_label_line(pick_name_len(), 1);
                else
                    add_junk_line();
            end
        end
        r = $urandom_range(0, 9);
        if (r < 3)
            add_label_line(pick_name_len(), 0);
        else if (r < 5)
            prog_q.push_back($urandom_range(0, 255));
        if (prog_q.size() == 0)
            prog_q.push_back($urandom_range(0, 255));
    endfunction

    function automatic void gen_lookup();
        int slot;
        int n;
        int r;
        look_q.delete();
        r = $urandom_range(0, 9);
        if (pool_count == 0 && r < 6)
            r = 9;
        slot = (pool_count == 0) ? 0 : $urandom_range(0, pool_count - 1);
        n = name_pool_len[slot];
        case (r)
            0, 1, 2, 3, 4: begin
                // Stored name, sometimes cut to the table's name width
                if (n > NAME_BYTES && $urandom_range(0, 1) == 1)
                    n = NAME_BYTES;
                for (int k = 0; k < n; k++)
                    look_q.push_back(name_pool[slot][k]);
            end
            5: begin
                for (int k = 0; k < n; k++)
                    look_q.push_back(name_pool[slot][k]);
                case ($urandom_range(0, 2))
                    0: if (look_q.size() > 0) void'(look_q.pop_back());
                    1: look_q.push_back(8'h61 + $urandom_range(0, 3));
                    default: if (n > 0) look_q[$urandom_range(0, n - 1)] ^= 8'h01;
                endcase
            end
            6: look_q.push_back(CHAR_NUL);
            7: begin
                for (int k = 0; k < n; k++)
                    look_q.push_back(name_pool[slot][k]);
                look_q.push_back(CHAR_NUL);
                repeat ($urandom_range(1, 4)) look_q.push_back($urandom_range(0, 255));
            end
            8: repeat ($urandom_range(32, 70)) look_q.push_back($urandom_range(1, 255));
            default: repeat ($urandom_range(1, 4)) look_q.push_back(8'h61 + $urandom_range(0, 3));
        endcase
        if (look_q.size() == 0)
            look_q.push_back(CHAR_NUL);
    endfunction

    initial begin
        int r;
        board = new();

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: normal, broken-prefix, empty, zero-ended, long and unterminated labels
        prog_q.delete();
        add_text("label ab\nlabex no\nlab\nlabel \nlabel c");
        prog_q.push_back(CHAR_NUL);
        add_text("zz\n label sp\nlabel ");
        prog_q.push_back(8'hFF);
        add_text("\nlabel ");
        for (int k = 0; k < 40; k++)
            prog_q.push_back(8'h6B + k % 3);
        add_text("\nlabel e");
        send_stream(CMD_SCAN);
        lookup_text("ab");
        lookup_text("c");
        lookup_text("");
        lookup_text("e");
        lookup_text("zz");
        lookup_text("sp");
        look_q.delete();
        look_q = '{8'h61, 8'h62, CHAR_NUL, 8'h71};
        send_stream(CMD_LOOKUP);
        look_q.delete();
        look_q.push_back(8'hFF);
        send_stream(CMD_LOOKUP);
        lookup_long(NAME_BYTES);
        lookup_long(POOL_BYTES);
        lookup_long(70);

        // Directed: more labels than the table holds
        prog_q.delete();
        repeat (36) add_label_line($urandom_range(1, 2), 1);
        send_stream(CMD_SCAN);
        repeat (4) begin
            gen_lookup();
            send_stream(CMD_LOOKUP);
        end

        // Back-pressure: the receiver holds off while lookups keep coming
        gen_program();
        send_stream(CMD_SCAN);
        hold_request = 1'b1;
        repeat (30) begin
            gen_lookup();
            send_stream(CMD_LOOKUP);
        end

        // Random traffic, mostly well-formed programs and lookups
        while (board.items_noted < 1800) begin
            if ($urandom_range(0, 11) == 0) begin
                stall_mode = $urandom_range(0, 3);
                idle_on = ($urandom_range(0, 3) != 0);
            end
            r = $urandom_range(0, 19);
            if (r < 7) begin
                gen_program();
                send_stream(CMD_SCAN);
            end
            else if (r < 15) begin
                gen_lookup();
                send_stream(CMD_LOOKUP);
            end
            else if (r < 18) begin
                gen_program();
                gen_lookup();
                send_mixed();
            end
            else
                push_item(make_item($urandom_range(0, 1), $urandom_range(0, 255),
                                    $urandom_range(0, 1)));
        end

        // Drain the result queue, then let the pipeline settle
        @(negedge clk);
        req_valid <= 1'b0;
        stall_mode = 1;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Drove %0d items: %0d scan reports and %0d lookup answers (%0d found).",
                 board.items_noted, board.scan_reports, board.lookup_answers,
                 board.lookup_found);
        $display("Results checked: %0d, field mismatches or stray results: %0d.",
                 board.checked, board.errors);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
